FILE: src/swrl_pkg.sv
package swrl_pkg;

	// field widths fixed by the interface
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 4;
	localparam int TIME_W  = 32;
	localparam int LIMIT_W = 16;

	// default sizing
	localparam int NUM_LIMITERS_DEF = 16;
	localparam int RING_DEPTH_DEF   = 64;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_CHECK  = 2'd0,
		CMD_RESET  = 2'd1,
		CMD_CREATE = 2'd2,
		CMD_NOP    = 2'd3
	} swrl_cmd_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DECODE,
		ST_POP_RD,
		ST_POP_CMP,
		ST_ADMIT,
		ST_WB,
		ST_DONE
	} swrl_state_t;

endpackage

FILE: src/sliding_window_rate_limiter_unit.sv
// Bank of NUM_LIMITERS sliding-window-log rate limiters, each logging up to RING_DEPTH
// timestamps in one shared stamp memory. One request word is taken at a time: req_ready is
// high only while the sequencer is idle, and a finished result sits in the response register
// so the next word can be taken while it waits. Every word passes the lookup and decode states. A
// no-op, a check on an unconfigured slot, or a reset or create that leaves the slot table alone
// then gives its result; a reset or create that rewrites the slot record first writes it back. A check
// on a configured slot walks the ring, popping expired entries until a live entry or an empty
// ring ends the walk, then admits and writes back. The walk reads one entry at a time through the
// single read port of the stamp memory, which feeds the one age comparator.
// The slot table is a memory read once and written at most once per word.
// There is no clearing pass: only the per-slot active flags are reset.
module sliding_window_rate_limiter_unit import swrl_pkg::*; #(
	parameter int NUM_LIMITERS = NUM_LIMITERS_DEF,
	parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [IDX_W-1:0]   limiter_index,
	input  logic [TIME_W-1:0]  current_time_ms,
	input  logic [TIME_W-1:0]  window_length,
	input  logic [LIMIT_W-1:0] request_limit,
	input  logic [LIMIT_W-1:0] burst_allowance,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               allowed,
	output logic               status
);

	localparam int SLOT_W      = (NUM_LIMITERS > 1) ? $clog2(NUM_LIMITERS) : 1;
	localparam int SLOT_DEPTH  = 1 << SLOT_W;
	localparam int HEAD_W      = $clog2(RING_DEPTH);
	localparam int CNT_W       = $clog2(RING_DEPTH + 1);
	localparam int STAMP_AW    = SLOT_W + HEAD_W;
	localparam int STAMP_DEPTH = 1 << STAMP_AW;
	localparam int IDX_EXT_W   = SLOT_W + IDX_W;
	localparam int SUM_W       = CNT_W + 1;
	localparam int BOUND_W     = LIMIT_W + 1;
	localparam int SLOT_WORD_W = TIME_W + 2 * LIMIT_W + HEAD_W + CNT_W;

	swrl_state_t state_q, state_d;

	// captured request word
	swrl_cmd_t          cmd_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               idx_ok_q;
	logic [TIME_W-1:0]  time_q;
	logic [TIME_W-1:0]  win_in_q;
	logic [LIMIT_W-1:0] lim_in_q;
	logic [LIMIT_W-1:0] bur_in_q;

	// working copy of the slot record
	logic [TIME_W-1:0]  win_q;
	logic [LIMIT_W-1:0] lim_q;
	logic [LIMIT_W-1:0] bur_q;
	logic [HEAD_W-1:0]  head_q;
	logic [CNT_W-1:0]   cnt_q;

	logic res_allowed_q;
	logic res_status_q;
	logic rsp_valid_q;
	logic allowed_q;
	logic status_q;

	logic [NUM_LIMITERS-1:0] active_q;

	logic                 req_fire;
	logic                 out_free;
	logic [IDX_EXT_W-1:0] idx_ext;
	logic                 slot_active;
	logic                 expired;
	logic [HEAD_W-1:0]    head_inc;
	logic [SUM_W-1:0]     tail_sum;
	logic [HEAD_W-1:0]    tail;
	logic [BOUND_W-1:0]   bound;
	logic                 admit;

	logic                   slot_re;
	logic                   slot_we;
	logic [SLOT_WORD_W-1:0] slot_wdata;
	logic [SLOT_WORD_W-1:0] slot_rdata;
	logic [TIME_W-1:0]      rd_win;
	logic [LIMIT_W-1:0]     rd_lim;
	logic [LIMIT_W-1:0]     rd_bur;
	logic [HEAD_W-1:0]      rd_head;
	logic [CNT_W-1:0]       rd_cnt;

	logic                stamp_re;
	logic                stamp_we;
	logic [STAMP_AW-1:0] stamp_raddr;
	logic [STAMP_AW-1:0] stamp_waddr;
	logic [TIME_W-1:0]   stamp_rdata;

	assign req_fire = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign idx_ext  = IDX_EXT_W'(limiter_index);

	// slot table: window, limit, burst, head and count per slot
	swrl_ram #(
		.WIDTH(SLOT_WORD_W),
		.DEPTH(SLOT_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_q),
		.wdata(slot_wdata),
		.re   (slot_re),
		.raddr(slot_q),
		.rdata(slot_rdata)
	);

	assign {rd_win, rd_lim, rd_bur, rd_head, rd_cnt} = slot_rdata;
	assign slot_wdata = {win_q, lim_q, bur_q, head_q, cnt_q};

	// stamp rings of all slots, one row of the address per slot
	swrl_ram #(
		.WIDTH(TIME_W),
		.DEPTH(STAMP_DEPTH)
	) u_stamp_ram (
		.clk  (clk),
		.we   (stamp_we),
		.waddr(stamp_waddr),
		.wdata(time_q),
		.re   (stamp_re),
		.raddr(stamp_raddr),
		.rdata(stamp_rdata)
	);

	// shared age compare for the expiry walk
	swrl_age_unit u_age (
		.now    (time_q),
		.stamp  (stamp_rdata),
		.window (win_q),
		.expired(expired)
	);

	// ring pointer arithmetic and admission bound
	always_comb begin
		slot_active = idx_ok_q && active_q[slot_q];
		head_inc    = (head_q == HEAD_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_sum    = SUM_W'(head_q) + SUM_W'(cnt_q);
		if (tail_sum >= SUM_W'(RING_DEPTH)) begin
			tail = HEAD_W'(tail_sum - SUM_W'(RING_DEPTH));
		end else begin
			tail = HEAD_W'(tail_sum);
		end
		bound = BOUND_W'(lim_q) + BOUND_W'(bur_q);
		admit = (BOUND_W'(cnt_q) < bound) && (cnt_q < CNT_W'(RING_DEPTH));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (cmd_q)
					CMD_CHECK:  state_d = slot_active ? ST_POP_RD : ST_DONE;
					CMD_RESET:  state_d = slot_active ? ST_WB : ST_DONE;
					CMD_CREATE: state_d = idx_ok_q ? ST_WB : ST_DONE;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_POP_RD: begin
				state_d = (cnt_q == '0) ? ST_ADMIT : ST_POP_CMP;
			end
			ST_POP_CMP: begin
				state_d = expired ? ST_POP_RD : ST_ADMIT;
			end
			ST_ADMIT: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory strobes and handshake outputs
	always_comb begin
		req_ready   = (state_q == ST_IDLE);
		slot_re     = (state_q == ST_LOOKUP);
		slot_we     = (state_q == ST_WB);
		stamp_re    = (state_q == ST_POP_RD) && (cnt_q != '0);
		stamp_raddr = {slot_q, head_q};
		stamp_we    = (state_q == ST_ADMIT) && admit;
		stamp_waddr = {slot_q, tail};
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECODE && cmd_q == CMD_CREATE && idx_ok_q) begin
				active_q[slot_q] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture and slot record datapath
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q    <= swrl_cmd_t'(command);
			slot_q   <= idx_ext[SLOT_W-1:0];
			idx_ok_q <= 32'(limiter_index) < NUM_LIMITERS;
			time_q   <= current_time_ms;
			win_in_q <= window_length;
			lim_in_q <= request_limit;
			bur_in_q <= burst_allowance;
		end
		case (state_q)
			ST_DECODE: begin
				res_allowed_q <= 1'b0;
				res_status_q  <= 1'b0;
				if (cmd_q == CMD_CREATE) begin
					win_q  <= win_in_q;
					lim_q  <= lim_in_q;
					bur_q  <= bur_in_q;
					head_q <= '0;
					cnt_q  <= '0;
				end else begin
					win_q  <= rd_win;
					lim_q  <= rd_lim;
					bur_q  <= rd_bur;
					head_q <= rd_head;
					cnt_q  <= (cmd_q == CMD_RESET) ? '0 : rd_cnt;
				end
				if (cmd_q == CMD_CHECK && !slot_active) begin
					res_allowed_q <= 1'b1;
				end
				if (cmd_q == CMD_RESET && !slot_active) begin
					res_status_q <= 1'b1;
				end
			end
			ST_POP_CMP: begin
				if (expired) begin
					head_q <= head_inc;
					cnt_q  <= cnt_q - 1'b1;
				end
			end
			ST_ADMIT: begin
				if (admit) begin
					cnt_q         <= cnt_q + 1'b1;
					res_allowed_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			allowed_q <= res_allowed_q;
			status_q  <= res_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign allowed   = allowed_q;
	assign status    = status_q;

	// an accepted word always starts with the slot table lookup
	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q == ST_LOOKUP)
		else $error("accepted word did not start a lookup");

	// the ring count never passes the ring depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_RD || state_q == ST_POP_CMP || state_q == ST_ADMIT ||
		 state_q == ST_WB) |-> cnt_q <= CNT_W'(RING_DEPTH))
		else $error("ring count above depth");

	// a stamp is logged only into a ring that has room
	a_stamp_room: assert property (@(posedge clk) disable iff (!arst_n)
		stamp_we |-> cnt_q < CNT_W'(RING_DEPTH))
		else $error("stamp logged into a full ring");

	// a response appears only as the sequencer leaves its done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside done state");

	// a word is never both admitted and flagged
	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(allowed_q && status_q))
		else $error("allowed and status both set");

endmodule

FILE: src/swrl_ram.sv
module swrl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/swrl_age_unit.sv
module swrl_age_unit import swrl_pkg::*; (
	input  logic [TIME_W-1:0] now,
	input  logic [TIME_W-1:0] stamp,
	input  logic [TIME_W-1:0] window,
	output logic              expired
);

	logic [TIME_W-1:0] age;

	// modular age of a logged word, expired once strictly past the window
	always_comb begin
		age     = now - stamp;
		expired = age > window;
	end

endmodule

FILE: tb/sv/tb_sliding_window_rate_limiter_unit.sv
module tb_sliding_window_rate_limiter_unit;
	import swrl_pkg::*;

	localparam int SLOTS         = NUM_LIMITERS_DEF;
	localparam int DEPTH         = RING_DEPTH_DEF;
	localparam int HEAD_BITS     = $clog2(DEPTH);
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 40;
	localparam int RANDOM_BLOCKS = 36;
	localparam int BLOCK_WORDS   = 40;

	typedef struct packed {
		logic allowed;
		logic status;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [CMD_W-1:0] command = CMD_NOP;
	logic [IDX_W-1:0] limiter_index = '0;
	logic [TIME_W-1:0] current_time_ms = '0;
	logic [TIME_W-1:0] window_length = '0;
	logic [LIMIT_W-1:0] request_limit = '0;
	logic [LIMIT_W-1:0] burst_allowance = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic allowed;
	logic status;

	// shared between the sender, the receiver and the checker
	verdict_t verdict_queue[$];
	int mismatches = 0;
	bit no_idle = 1'b0;
	int hold_requests = 0;

	// own copy of the limiter bank
	logic [TIME_W-1:0] stamp_log [SLOTS][DEPTH];
	int unsigned log_head [SLOTS];
	int unsigned log_fill [SLOTS];
	bit slot_live [SLOTS];
	logic [TIME_W-1:0] slot_win [SLOTS];
	int unsigned slot_lim [SLOTS];
	int unsigned slot_extra [SLOTS];

	sliding_window_rate_limiter_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.command         (command),
		.limiter_index   (limiter_index),
		.current_time_ms (current_time_ms),
		.window_length   (window_length),
		.request_limit   (request_limit),
		.burst_allowance (burst_allowance),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.allowed         (allowed),
		.status          (status)
	);

	always #1 clk = ~clk;

	// admission verdict for one request word, updating the bank copy
	function automatic verdict_t predict_verdict(input swrl_cmd_t cmd,
		input logic [IDX_W-1:0] slot, input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] win, input logic [LIMIT_W-1:0] lim,
		input logic [LIMIT_W-1:0] burst);
		verdict_t v;
		logic [TIME_W-1:0] age;
		int unsigned room;
		bit walking;
		v = '0;
		case (cmd)
			CMD_CHECK: begin
				if (!slot_live[slot]) begin
					v.allowed = 1'b1;
				end else begin
					// drop expired stamps from the oldest end
					walking = 1'b1;
					while (walking && log_fill[slot] > 0) begin
						age = now - stamp_log[slot][HEAD_BITS'(log_head[slot])];
						if (age > slot_win[slot]) begin
							log_head[slot] = (log_head[slot] + 1) % DEPTH;
							log_fill[slot]--;
						end else begin
							walking = 1'b0;
						end
					end
					room = slot_lim[slot] + slot_extra[slot];
					if (room > DEPTH)
						room = DEPTH;
					if (log_fill[slot] < room) begin
						stamp_log[slot][HEAD_BITS'((log_head[slot] + log_fill[slot]) % DEPTH)] = now;
						log_fill[slot]++;
						v.allowed = 1'b1;
					end
				end
			end
			CMD_RESET: begin
				if (slot_live[slot])
					log_fill[slot] = 0;
				else
					v.status = 1'b1;
			end
			CMD_CREATE: begin
				slot_win[slot] = win;
				slot_lim[slot] = 32'(lim);
				slot_extra[slot] = 32'(burst);
				log_head[slot] = 0;
				log_fill[slot] = 0;
				slot_live[slot] = 1'b1;
			end
			default: ;
		endcase
		return v;
	endfunction

	// offer one request word and log its expected verdict once taken
	task automatic send_request(input swrl_cmd_t cmd, input logic [IDX_W-1:0] slot,
		input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] win,
		input logic [LIMIT_W-1:0] lim, input logic [LIMIT_W-1:0] burst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		command <= cmd;
		limiter_index <= slot;
		current_time_ms <= now;
		window_length <= win;
		request_limit <= lim;
		burst_allowance <= burst;
		do @(posedge clk); while (!req_ready);
		verdict_queue.push_back(predict_verdict(cmd, slot, now, win, lim, burst));
	endtask

	// check word with junk in the fields that a check ignores
	task automatic send_check(input logic [IDX_W-1:0] slot, input logic [TIME_W-1:0] now);
		send_request(CMD_CHECK, slot, now, $urandom, LIMIT_W'($urandom),
			LIMIT_W'($urandom));
	endtask

	// settings for a create, spread over short, long and extreme windows and bounds
	task automatic draw_settings(output logic [TIME_W-1:0] win, output logic [LIMIT_W-1:0] lim,
		output logic [LIMIT_W-1:0] burst);
		case ($urandom_range(0, 4))
			0: win = '0;
			1: win = $urandom_range(1, 50);
			2: win = $urandom_range(50, 1000);
			3: win = $urandom_range(1000, 20000);
			default: win = $urandom;
		endcase
		case ($urandom_range(0, 5))
			0, 1: begin
				lim = LIMIT_W'($urandom_range(0, 6));
				burst = LIMIT_W'($urandom_range(0, 3));
			end
			2, 3: begin
				lim = LIMIT_W'($urandom_range(20, 60));
				burst = LIMIT_W'($urandom_range(0, 30));
			end
			4: begin
				lim = LIMIT_W'($urandom);
				burst = LIMIT_W'($urandom);
			end
			default: begin
				lim = '0;
				burst = '0;
			end
		endcase
	endtask

	// unconfigured slots, bound edges, expiry boundary, wrap of time, reload, no-op
	task automatic test_special_cases();
		send_check(4'd5, 32'd1000);
		send_request(CMD_RESET, 4'd6, 32'd1000, '0, '0, '0);
		send_request(CMD_NOP, 4'd0, 32'd1000, '0, '0, '0);
		send_request(CMD_CREATE, 4'd1, 32'd1000, 32'd100, 16'd2, 16'd1);
		send_check(4'd1, 32'd1000);
		send_check(4'd1, 32'd1010);
		send_check(4'd1, 32'd1020);
		send_check(4'd1, 32'd1030);
		// oldest stamp exactly one window old still counts
		send_check(4'd1, 32'd1100);
		send_check(4'd1, 32'd1101);
		send_request(CMD_RESET, 4'd1, 32'd1101, '1, '1, '1);
		send_check(4'd1, 32'd1102);
		// zero bound refuses everything
		send_request(CMD_CREATE, 4'd2, 32'd0, 32'd0, 16'd0, 16'd0);
		send_check(4'd2, 32'd0);
		// widest settings, bound capped at the ring depth
		send_request(CMD_CREATE, 4'd3, '1, '1, '1, '1);
		send_check(4'd3, 32'hFFFF_FFF0);
		send_check(4'd3, 32'h0000_0005);
		// reload of a live slot empties it
		send_request(CMD_CREATE, 4'd1, 32'd2000, 32'd5, 16'd1, 16'd0);
		send_check(4'd1, 32'd2000);
		send_check(4'd1, 32'd2003);
		// expiry across the wrap of time
		send_request(CMD_CREATE, 4'd15, 32'hFFFF_FFF0, 32'd10, 16'd0, 16'd1);
		send_check(4'd15, 32'hFFFF_FFFE);
		send_check(4'd15, 32'h0000_0009);
		send_request(CMD_NOP, 4'd15, '1, '1, '1, '1);
	endtask

	// fill one ring to the depth, overrun it, then expire the lot in one walk
	task automatic test_full_ring();
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] win;
		base = $urandom;
		win = $urandom_range(1000, 2000);
		send_request(CMD_CREATE, 4'd4, base, win, 16'd60, 16'd20);
		for (int i = 0; i < DEPTH + 2; i++)
			send_check(4'd4, base + i / 8);
		send_check(4'd4, base + win + 100);
	endtask

	// receiver holds off while words keep coming, so the input stalls
	task automatic test_output_stall();
		logic [TIME_W-1:0] now;
		now = $urandom;
		no_idle = 1'b1;
		send_request(CMD_CREATE, 4'd7, now, 32'd50, 16'd4, 16'd2);
		hold_requests++;
		for (int i = 0; i < 12; i++)
			send_check(4'd7, now + 3 * i);
		no_idle = 1'b0;
	endtask

	// blocks of traffic centred on one slot, with other commands mixed in
	task automatic test_random_traffic();
		logic [TIME_W-1:0] clock_ms;
		logic [TIME_W-1:0] win;
		logic [LIMIT_W-1:0] lim;
		logic [LIMIT_W-1:0] burst;
		logic [IDX_W-1:0] hot;
		int step_max;
		int pick;
		clock_ms = $urandom;
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			hot = IDX_W'($urandom_range(0, SLOTS - 1));
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 4))
				0: step_max = 0;
				1: step_max = 3;
				2: step_max = 20;
				3: step_max = 150;
				default: step_max = 2000;
			endcase
			if ($urandom_range(0, 1)) begin
				draw_settings(win, lim, burst);
				send_request(CMD_CREATE, hot, clock_ms, win, lim, burst);
			end
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				clock_ms += $urandom_range(0, step_max);
				if ($urandom_range(0, 99) == 0)
					clock_ms = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < 72) begin
					send_check(hot, clock_ms);
				end else if (pick < 82) begin
					send_check(IDX_W'($urandom_range(0, SLOTS - 1)), clock_ms);
				end else if (pick < 88) begin
					send_request(CMD_RESET, IDX_W'($urandom_range(0, SLOTS - 1)), clock_ms,
						$urandom, LIMIT_W'($urandom), LIMIT_W'($urandom));
				end else if (pick < 95) begin
					draw_settings(win, lim, burst);
					send_request(CMD_CREATE, IDX_W'($urandom_range(0, SLOTS - 1)), clock_ms,
						win, lim, burst);
				end else begin
					send_request(CMD_NOP, IDX_W'($urandom_range(0, SLOTS - 1)), clock_ms,
						$urandom, LIMIT_W'($urandom), LIMIT_W'($urandom));
				end
			end
		end
		no_idle = 1'b0;
	endtask

	// result receiver: random waits per word, plus the long hold on request
	int hold_served = 0;
	int hold_left = 0;
	int rsp_wait = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (rsp_ready && rsp_valid) begin
			rsp_wait = no_idle ? 0 : $urandom_range(0, 16);
			rsp_ready <= (rsp_wait == 0);
		end else if (!rsp_ready) begin
			if (rsp_wait > 0)
				rsp_wait--;
			rsp_ready <= (rsp_wait == 0);
		end
	end

	// compare each result word with the oldest expected verdict
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (verdict_queue.size() == 0) begin
				$error("result word with no request outstanding: allowed %0b status %0b",
					allowed, status);
				mismatches++;
			end else begin
				want = verdict_queue.pop_front();
				if (allowed !== want.allowed) begin
					$error("allowed: expected %0b, got %0b", want.allowed, allowed);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0b, got %0b", want.status, status);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[sliding_window_rate_limiter_unit] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_full_ring();
		test_output_stall();
		test_random_traffic();
		req_valid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[sliding_window_rate_limiter_unit] OK");
		else
			$display("[sliding_window_rate_limiter_unit] ERROR");
		$finish;
	end

endmodule
